>>> hdl/seven_segment_text_scan_driver_defines.svh
// ============================================================================
// Assertion macros for the seven-segment scan driver
// Concurrent checks clocked on clk, with and without reset gating.
// ============================================================================
`ifndef SEVEN_SEGMENT_TEXT_SCAN_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_TEXT_SCAN_DRIVER_DEFINES_SVH

`ifndef SYNTH
// check that is off while rst_n is low
`define SSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define SSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSD_ASSERT(lbl, prop, msg)
`define SSD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/ssd_pkg.sv
// ============================================================================
// ssd_pkg
// Shared constants, codes, types and the glyph table of the scan driver.
// ============================================================================
package ssd_pkg;

  localparam int DIGITS_PER_CHIP = 8;
  localparam int MAX_CHIPS_DEF   = 4;
  localparam int ROW_W           = 3;   // digit row within a chip
  localparam int CHIP_W          = 3;   // chip count / chip index
  localparam int COUNT_W         = 6;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 4;

  // command codes
  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_CHAR    = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  // character status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WORD   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHIPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY = 2'd2;

  localparam logic [3:0] REG_INTENSITY = 4'hA;
  localparam logic [7:0] POINT_BIT     = 8'h80;
  localparam logic [7:0] GLYPH_UNKNOWN = 8'hFF;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_TILDE    = 8'h7E;
  localparam logic [7:0] CHAR_POINT    = 8'h2E;

  typedef struct packed {
    logic [CHIP_W-1:0] chips;      // clamped to 1..MAX_CHIPS
    logic              reverse;
    logic [3:0]        intensity;
    logic              pending;    // intensity frame owed at next refresh
  } cfg_t;

  // printable ASCII 0x20..0x7E
  localparam logic [7:0] GLYPH_TBL [0:94] = '{
    8'h00, 8'hB0, 8'h22, 8'hFF, 8'hFF, 8'h49, 8'hFF, 8'h02,
    8'h4E, 8'h78, 8'h40, 8'hFF, 8'h10, 8'h01, 8'h80, 8'hFF,
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h48, 8'h58, 8'hFF, 8'h09, 8'hFF, 8'h65,
    8'h6F, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E,
    8'h37, 8'h30, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h7E,
    8'h67, 8'hFE, 8'h05, 8'h5B, 8'h07, 8'h3E, 8'h3E, 8'h3F,
    8'hFF, 8'h27, 8'h6D, 8'h4E, 8'hFF, 8'h78, 8'hFF, 8'h08,
    8'h20, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E,
    8'h17, 8'h10, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h1D,
    8'h67, 8'hFF, 8'h05, 8'h5B, 8'h07, 8'h1C, 8'h1C, 8'hFF,
    8'hFF, 8'h27, 8'hFF, 8'h31, 8'h06, 8'h07, 8'h63
  };

  function automatic logic [7:0] glyph_of(logic [7:0] ch);
    logic [7:0] ofs;
    ofs = ch - CHAR_SPACE;
    if (ch >= CHAR_SPACE && ch <= CHAR_TILDE) begin
      return GLYPH_TBL[ofs[6:0]];
    end
    return GLYPH_UNKNOWN;
  endfunction

endpackage

>>> hdl/ssd_ifs.sv
// ============================================================================
// ssd_in_if / ssd_out_if
// Valid/ready channels of the scan driver: command items and results.
// ============================================================================
interface ssd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;
  logic       first_char;
  logic [4:0] str_pos;

  modport source (output valid, cmd, char_code, first_char, str_pos, input ready);
  modport sink   (input valid, cmd, char_code, first_char, str_pos, output ready);
endinterface

interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] reg_addr;
  logic [7:0] data_byte;
  logic       frame_end;
  logic       last;
  logic [1:0] status;
  logic [5:0] count;

  modport source (output valid, kind, reg_addr, data_byte, frame_end, last, status, count,
                  input ready);
  modport sink   (input valid, kind, reg_addr, data_byte, frame_end, last, status, count,
                  output ready);
endinterface

>>> hdl/ssd_ram.sv
// ============================================================================
// ssd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/ssd_cfg.sv
// ============================================================================
// ssd_cfg
// Configuration registers, chip count clamp and intensity-pending flag.
// ============================================================================
module ssd_cfg #(
  parameter int MAX_CHIPS = ssd_pkg::MAX_CHIPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             pend_clr,
  output ssd_pkg::cfg_t                    cfg
);

  logic [ssd_pkg::CHIP_W-1:0] num_chips_r, num_chips_nxt;
  logic                       reverse_r, reverse_nxt;
  logic [3:0]                 intensity_r, intensity_nxt;
  logic                       pending_r, pending_nxt;

  always_comb begin
    num_chips_nxt = num_chips_r;
    reverse_nxt   = reverse_r;
    intensity_nxt = intensity_r;
    pending_nxt   = pending_r && !pend_clr;
    if (cfg_we) begin
      case (cfg_idx)
        ssd_pkg::CFG_NUM_CHIPS: num_chips_nxt = cfg_wdata[ssd_pkg::CHIP_W-1:0];
        ssd_pkg::CFG_REVERSE:   reverse_nxt   = cfg_wdata[0];
        ssd_pkg::CFG_INTENSITY: begin
          // only a changed value owes a new intensity frame
          if (cfg_wdata[3:0] != intensity_r) begin
            intensity_nxt = cfg_wdata[3:0];
            pending_nxt   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_chips_r <= ssd_pkg::CHIP_W'(1);
      reverse_r   <= 1'b0;
      intensity_r <= 4'd0;
      pending_r   <= 1'b1;
    end else begin
      num_chips_r <= num_chips_nxt;
      reverse_r   <= reverse_nxt;
      intensity_r <= intensity_nxt;
      pending_r   <= pending_nxt;
    end
  end

  always_comb begin
    if (num_chips_r == '0) begin
      cfg.chips = ssd_pkg::CHIP_W'(1);
    end else if (int'(num_chips_r) > MAX_CHIPS) begin
      cfg.chips = ssd_pkg::CHIP_W'(MAX_CHIPS);
    end else begin
      cfg.chips = num_chips_r;
    end
    cfg.reverse   = reverse_r;
    cfg.intensity = intensity_r;
    cfg.pending   = pending_r;
  end

endmodule

>>> hdl/ssd_seq.sv
// ============================================================================
// ssd_seq
// Command sequencer: character writes and point read-modify-write on the
// digit RAM, refresh scan-out and the result register.
// ============================================================================
`include "seven_segment_text_scan_driver_defines.svh"

module ssd_seq #(
  parameter int MAX_CHIPS = ssd_pkg::MAX_CHIPS_DEF,
  localparam int BUF_LEN  = MAX_CHIPS * ssd_pkg::DIGITS_PER_CHIP,
  localparam int AW       = $clog2(BUF_LEN)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ssd_pkg::cfg_t    cfg,
  output logic             pend_clr,
  ssd_in_if.sink           in_ch,
  ssd_out_if.source        out_ch,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [7:0]       ram_wdata,
  output logic             ram_re,
  output logic [AW-1:0]    ram_raddr,
  input  logic [7:0]       ram_rdata
);

  localparam int CUR_W = ($clog2(BUF_LEN + 1) > ssd_pkg::COUNT_W) ?
                         $clog2(BUF_LEN + 1) : ssd_pkg::COUNT_W;
  localparam int CW    = ssd_pkg::CHIP_W;
  localparam int RW    = ssd_pkg::ROW_W;
  // highest cursor: one past the last start position, or the buffer end
  localparam int CUR_MAX = (BUF_LEN > 32) ? BUF_LEN : 32;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PTRD = 6'b000010,   // point: read data back, OR and write
    S_STAT = 6'b000100,   // character status result
    S_INT  = 6'b001000,   // intensity frame
    S_SCRD = 6'b010000,   // first scan read
    S_SCAN = 6'b100000    // scan words
  } state_t;

  state_t               state_r, state_nxt;
  logic [CUR_W-1:0]     cursor_r, cursor_nxt;
  logic [4:0]           start_r, start_nxt;
  logic                 stopped_r, stopped_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [AW-1:0]        pt_addr_r, pt_addr_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CW-1:0]        chip_r, chip_nxt;
  logic [BUF_LEN-1:0]   valid_r, valid_nxt;
  logic                 vld_rd_r, vld_rd_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [3:0]           out_reg_r, out_reg_nxt;
  logic [7:0]           out_data_r, out_data_nxt;
  logic                 out_fe_r, out_fe_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [5:0]           out_count_r, out_count_nxt;

  logic                 in_fire, out_free;
  logic [7:0]           glyph, rd_eff;
  logic [CUR_W-1:0]     cur_in, pc, limit;
  logic [4:0]           st_in;
  logic                 stop_in;
  logic                 last_j, last_row;
  logic [RW-1:0]        row_adv;
  logic [CW-1:0]        chip_adv;

  function automatic logic [AW-1:0] scan_addr(logic [RW-1:0] row, logic [CW-1:0] j,
                                              logic [CW-1:0] n, logic rev);
    logic [CW-1:0]    chip;
    logic [CW+RW-1:0] idx;
    chip = rev ? (n - CW'(1) - j) : j;
    idx  = {chip, row};
    return idx[AW-1:0];
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign glyph   = ssd_pkg::glyph_of(in_ch.char_code);
  assign limit   = CUR_W'({cfg.chips, {RW{1'b0}}});
  assign cur_in  = in_ch.first_char ? CUR_W'(in_ch.str_pos) : cursor_r;
  assign st_in   = in_ch.first_char ? in_ch.str_pos : start_r;
  assign stop_in = in_ch.first_char ? 1'b0 : stopped_r;
  assign pc      = (cur_in != CUR_W'(st_in)) ? cur_in - CUR_W'(1) : cur_in;
  assign rd_eff  = vld_rd_r ? ram_rdata : 8'h00;   // entries not written since reset or the last clear read as blank

  assign last_j   = (chip_r == cfg.chips - CW'(1));
  assign last_row = (row_r == RW'(ssd_pkg::DIGITS_PER_CHIP - 1));
  assign chip_adv = last_j ? '0 : chip_r + CW'(1);
  assign row_adv  = last_j ? row_r + RW'(1) : row_r;

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    start_nxt      = start_r;
    stopped_nxt    = stopped_r;
    status_nxt     = status_r;
    pt_addr_nxt    = pt_addr_r;
    row_nxt        = row_r;
    chip_nxt       = chip_r;
    valid_nxt      = valid_r;
    pend_clr       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_reg_nxt    = out_reg_r;
    out_data_nxt   = out_data_r;
    out_fe_nxt     = out_fe_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.cmd)
            ssd_pkg::CMD_CLEAR: valid_nxt = '0;
            ssd_pkg::CMD_CHAR: begin
              cursor_nxt  = cur_in;
              start_nxt   = st_in;
              stopped_nxt = stop_in;
              status_nxt  = ssd_pkg::ST_OK;
              state_nxt   = S_STAT;
              if (stop_in) begin
                status_nxt = ssd_pkg::ST_OVERFLOW;
              end else if (in_ch.char_code == ssd_pkg::CHAR_POINT) begin
                cursor_nxt = CUR_W'(ssd_pkg::COUNT_W'(pc + CUR_W'(1)));
                if (pc < limit) begin
                  ram_re      = 1'b1;
                  ram_raddr   = pc[AW-1:0];
                  pt_addr_nxt = pc[AW-1:0];
                  state_nxt   = S_PTRD;
                end
              end else if (cur_in >= limit) begin
                stopped_nxt = 1'b1;
                status_nxt  = ssd_pkg::ST_OVERFLOW;
              end else begin
                ram_we                 = 1'b1;
                ram_waddr              = cur_in[AW-1:0];
                ram_wdata              = glyph;
                valid_nxt[cur_in[AW-1:0]] = 1'b1;
                cursor_nxt             = cur_in + CUR_W'(1);
                if (glyph == ssd_pkg::GLYPH_UNKNOWN) begin
                  status_nxt = ssd_pkg::ST_UNKNOWN;
                end
              end
            end
            ssd_pkg::CMD_REFRESH: begin
              row_nxt  = '0;
              chip_nxt = '0;
              if (cfg.pending) begin
                pend_clr  = 1'b1;
                state_nxt = S_INT;
              end else begin
                state_nxt = S_SCRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_PTRD: begin
        ram_we                = 1'b1;
        ram_waddr             = pt_addr_r;
        ram_wdata             = rd_eff | ssd_pkg::POINT_BIT;
        valid_nxt[pt_addr_r]  = 1'b1;
        state_nxt             = S_STAT;
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ssd_pkg::KIND_STATUS;
          out_reg_nxt    = '0;
          out_data_nxt   = '0;
          out_fe_nxt     = 1'b0;
          out_last_nxt   = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = ssd_pkg::COUNT_W'(cursor_r - CUR_W'(start_r));
          state_nxt      = S_IDLE;
        end
      end
      S_INT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ssd_pkg::KIND_WORD;
          out_reg_nxt    = ssd_pkg::REG_INTENSITY;
          out_data_nxt   = {4'h0, cfg.intensity};
          out_fe_nxt     = last_j;
          out_last_nxt   = 1'b0;
          out_status_nxt = ssd_pkg::ST_OK;
          out_count_nxt  = '0;
          chip_nxt       = chip_adv;
          if (last_j) begin
            state_nxt = S_SCRD;
          end
        end
      end
      S_SCRD: begin
        ram_re    = 1'b1;
        ram_raddr = scan_addr(row_r, chip_r, cfg.chips, cfg.reverse);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = ssd_pkg::KIND_WORD;
          out_reg_nxt    = 4'(ssd_pkg::DIGITS_PER_CHIP) - {1'b0, row_r};
          out_data_nxt   = rd_eff;
          out_fe_nxt     = last_j;
          out_last_nxt   = last_j && last_row;
          out_status_nxt = ssd_pkg::ST_OK;
          out_count_nxt  = '0;
          if (last_j && last_row) begin
            state_nxt = S_IDLE;
          end else begin
            // fetch the next word while this one goes out
            chip_nxt  = chip_adv;
            row_nxt   = row_adv;
            ram_re    = 1'b1;
            ram_raddr = scan_addr(row_adv, chip_adv, cfg.chips, cfg.reverse);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign vld_rd_nxt = ram_re ? valid_r[ram_raddr] : vld_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      start_r     <= '0;
      stopped_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      chip_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      start_r     <= start_nxt;
      stopped_r   <= stopped_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      chip_r      <= chip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r     <= status_nxt;
    pt_addr_r    <= pt_addr_nxt;
    vld_rd_r     <= vld_rd_nxt;
    out_kind_r   <= out_kind_nxt;
    out_reg_r    <= out_reg_nxt;
    out_data_r   <= out_data_nxt;
    out_fe_r     <= out_fe_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.reg_addr  = out_reg_r;
  assign out_ch.data_byte = out_data_r;
  assign out_ch.frame_end = out_fe_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.count     = out_count_r;

  // a stalled result stays offered until it is taken
  `SSD_ASSERT(a_out_hold, (out_valid_r && !out_ch.ready) |=> out_valid_r, "stalled result dropped")
  // cursor stays within one past the last start position or the buffer end
  `SSD_ASSERT(a_cursor_rng, cursor_r <= CUR_W'(CUR_MAX), "cursor out of range")
  // chip counter stays below the chips in use during a refresh
  `SSD_ASSERT(a_chip_rng, (state_r == S_INT || state_r == S_SCAN) |-> (chip_r < cfg.chips), "chip index out of range")
  // RMW interlock: no read and write of the digit RAM in the same cycle
  `SSD_ASSERT_ALWAYS(a_ram_excl, !(ram_we && ram_re), "RAM read and write overlap")

endmodule

>>> hdl/seven_segment_text_scan_driver.sv
// ============================================================================
// seven_segment_text_scan_driver
// Text-to-segment buffer and serial scan-out for a chain of 8-digit chips.
// ============================================================================
// The block keeps an 8-segment digit buffer of MAX_CHIPS*8 entries in a
// single RAM with registered read, next to one valid bit per entry so that a
// clear command needs only to reset the valid bits and no clearing pass runs after
// reset. Items are taken one at a time. A character passes through the status
// state and waits for the result register ('.' first does a read-modify-write
// of the previous digit when it lies in the chain; the sequencer holds off the
// next item until the write-back lands, so no forwarding is needed). A refresh
// sends n intensity words when pending and then 8*n digit words, where n is
// the clamped chip count; after a first read state primes the RAM, one word
// goes out per cycle while the sink keeps ready high, since the read of the
// next digit overlaps the transfer of the current one. Clear and the unused
// command return to idle with no result. Configuration writes are taken
// at any edge with cfg_we high and should only be issued while idle.
module seven_segment_text_scan_driver #(
  parameter int MAX_CHIPS = ssd_pkg::MAX_CHIPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // command items in, results out
  ssd_in_if.sink                          in_ch,
  ssd_out_if.source                       out_ch
);

  localparam int BUF_LEN = MAX_CHIPS * ssd_pkg::DIGITS_PER_CHIP;
  localparam int AW      = $clog2(BUF_LEN);

  ssd_pkg::cfg_t  cfg;
  logic           pend_clr;

  // digit RAM ports
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  // registers: chip count (clamped), order, intensity and its pending flag
  ssd_cfg #(
    .MAX_CHIPS (MAX_CHIPS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .pend_clr  (pend_clr),
    .cfg       (cfg)
  );

  // sequencer: owns cursor, string state, valid bits and the result register
  ssd_seq #(
    .MAX_CHIPS (MAX_CHIPS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pend_clr  (pend_clr),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // digit buffer, one segment byte per position
  ssd_ram #(
    .WIDTH (8),
    .DEPTH (BUF_LEN)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> tb/seven_segment_text_scan_driver_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// seven_segment_text_scan_driver_tb
// Self-checking bench for the seven-segment text buffer and chain scan-out.
// A predictor mirrors the digit buffer, the string cursor and the register
// state. It works out the status or serial words owed for every command
// transfer, and the monitor checks each result transfer against the oldest
// owed one. Stimulus is a short directed list, then random phases of strings
// and stray commands under several chip-count, order and intensity settings.
// ============================================================================
module seven_segment_text_scan_driver_tb;

  localparam int NCHIP         = ssd_pkg::MAX_CHIPS_DEF;
  localparam int BUF_LEN       = NCHIP * ssd_pkg::DIGITS_PER_CHIP;
  localparam int SETTLE_CYCLES = 12;      // covers the slowest no-result command
  localparam int CYCLE_LIMIT   = 200000;  // far above the slowest legal run

  // cmd 3 has no name in the package; the block must ignore it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // segment patterns of printable ASCII, space through tilde
  localparam logic [7:0] SEG_FONT [0:94] = '{
    8'h00, 8'hB0, 8'h22, 8'hFF, 8'hFF, 8'h49, 8'hFF, 8'h02,
    8'h4E, 8'h78, 8'h40, 8'hFF, 8'h10, 8'h01, 8'h80, 8'hFF,
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h48, 8'h58, 8'hFF, 8'h09, 8'hFF, 8'h65,
    8'h6F, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E,
    8'h37, 8'h30, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h7E,
    8'h67, 8'hFE, 8'h05, 8'h5B, 8'h07, 8'h3E, 8'h3E, 8'h3F,
    8'hFF, 8'h27, 8'h6D, 8'h4E, 8'hFF, 8'h78, 8'hFF, 8'h08,
    8'h20, 8'h77, 8'h1F, 8'h0D, 8'h3D, 8'h4F, 8'h47, 8'h5E,
    8'h17, 8'h10, 8'h3C, 8'hFF, 8'h0E, 8'hFF, 8'h15, 8'h1D,
    8'h67, 8'hFF, 8'h05, 8'h5B, 8'h07, 8'h1C, 8'h1C, 8'hFF,
    8'hFF, 8'h27, 8'hFF, 8'h31, 8'h06, 8'h07, 8'h63
  };

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic       first_char;
    logic [4:0] str_pos;
  } text_cmd_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] reg_addr;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       last;
    logic [1:0] status;
    logic [5:0] count;
  } scan_result_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ssd_in_if  in_ch ();
  ssd_out_if out_ch ();

  seven_segment_text_scan_driver #(
    .MAX_CHIPS (NCHIP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // --------------------------------------------------------------------------
  // Predictor state: digit buffer, string cursor and register copies
  // --------------------------------------------------------------------------
  logic [7:0] seg_buf [0:BUF_LEN-1];
  logic [5:0] cur_pos     = '0;
  logic [4:0] str_start   = '0;
  logic       str_stopped = 1'b0;
  logic [2:0] cfg_chips   = 3'd1;
  logic       cfg_rev     = 1'b0;
  logic [3:0] cfg_int     = 4'd0;
  logic       int_owed    = 1'b1;   // intensity frame goes out at first refresh

  text_cmd_t    cmd_queue    [$];   // commands waiting for the driver
  scan_result_t owed_results [$];   // results the block still has to deliver

  // bookkeeping
  int  cycles        = 0;
  int  mismatches    = 0;
  int  cmds_taken    = 0;
  int  chars_taken   = 0;
  int  scans_taken   = 0;
  int  results_seen  = 0;
  int  settings_used = 1;
  int  in_gap        = 0;
  int  out_hold      = 0;
  bit  in_xfer       = 1'b0;        // set at the edge where a command moved

  initial begin
    for (int i = 0; i < BUF_LEN; i++) begin
      seg_buf[i] = 8'h00;
    end
  end

  function automatic int chips_in_use();
    if (cfg_chips == 3'd0) return 1;
    if (cfg_chips > NCHIP) return NCHIP;
    return int'(cfg_chips);
  endfunction

  // Idle length for either side; no gaps while cycles[7:6] is 3, one window in four.
  function automatic int pause_len();
    if (cycles[7:6] == 2'd3) return 0;
    return $urandom_range(0, 4);
  endfunction

  task automatic owe_result(input logic kind, input logic [3:0] addr,
                            input logic [7:0] data, input logic fe, input logic lst,
                            input logic [1:0] st, input logic [5:0] cnt);
    scan_result_t r;
    r.kind      = kind;
    r.reg_addr  = addr;
    r.data_byte = data;
    r.frame_end = fe;
    r.last      = lst;
    r.status    = st;
    r.count     = cnt;
    owed_results.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Predictor: one command in, the owed results appended
  // --------------------------------------------------------------------------
  task automatic predict_display(input text_cmd_t c);
    int         n;
    int         lim;
    int         chip;
    logic [7:0] glyph;
    logic [1:0] st;
    n   = chips_in_use();
    lim = n * ssd_pkg::DIGITS_PER_CHIP;
    case (c.cmd)
      ssd_pkg::CMD_CLEAR: begin
        // wipes the buffer only; cursor and string state stay
        for (int i = 0; i < BUF_LEN; i++) begin
          seg_buf[i] = 8'h00;
        end
      end
      ssd_pkg::CMD_CHAR: begin
        if (c.first_char) begin
          cur_pos     = {1'b0, c.str_pos};
          str_start   = c.str_pos;
          str_stopped = 1'b0;
        end
        glyph = ssd_pkg::GLYPH_UNKNOWN;
        if (c.char_code >= ssd_pkg::CHAR_SPACE && c.char_code <= ssd_pkg::CHAR_TILDE) begin
          glyph = SEG_FONT[7'(c.char_code - ssd_pkg::CHAR_SPACE)];
        end
        st = ssd_pkg::ST_OK;
        if (str_stopped) begin
          st = ssd_pkg::ST_OVERFLOW;
        end else if (c.char_code == ssd_pkg::CHAR_POINT) begin
          // point lands on the previous digit, except at the string start
          if (cur_pos != {1'b0, str_start}) cur_pos = cur_pos - 6'd1;
          if (cur_pos < lim) seg_buf[cur_pos] = seg_buf[cur_pos] | ssd_pkg::POINT_BIT;
          cur_pos = cur_pos + 6'd1;
        end else if (cur_pos >= lim) begin
          str_stopped = 1'b1;
          st          = ssd_pkg::ST_OVERFLOW;
        end else begin
          seg_buf[cur_pos] = glyph;
          if (glyph == ssd_pkg::GLYPH_UNKNOWN) st = ssd_pkg::ST_UNKNOWN;
          cur_pos = cur_pos + 6'd1;
        end
        owe_result(ssd_pkg::KIND_STATUS, 4'd0, 8'd0, 1'b0, 1'b1, st,
                   cur_pos - {1'b0, str_start});
      end
      ssd_pkg::CMD_REFRESH: begin
        if (int_owed) begin
          for (int j = 0; j < n; j++) begin
            owe_result(ssd_pkg::KIND_WORD, ssd_pkg::REG_INTENSITY, {4'd0, cfg_int},
                       j == n - 1, 1'b0, ssd_pkg::ST_OK, 6'd0);
          end
          int_owed = 1'b0;
        end
        // row 0 goes to digit register 8, row 7 to register 1
        for (int row = 0; row < ssd_pkg::DIGITS_PER_CHIP; row++) begin
          for (int j = 0; j < n; j++) begin
            chip = cfg_rev ? n - 1 - j : j;
            owe_result(ssd_pkg::KIND_WORD, 4'(ssd_pkg::DIGITS_PER_CHIP - row),
                       seg_buf[chip * ssd_pkg::DIGITS_PER_CHIP + row], j == n - 1,
                       row == ssd_pkg::DIGITS_PER_CHIP - 1 && j == n - 1,
                       ssd_pkg::ST_OK, 6'd0);
          end
        end
      end
      default: ;  // unused command: no effect, no result
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: presents commands and output ready, both changed on the falling
  // edge. A command stays up until the edge that took it.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    text_cmd_t nxt;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_xfer) begin
        in_xfer = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          nxt = cmd_queue.pop_front();
          in_ch.cmd        <= nxt.cmd;
          in_ch.char_code  <= nxt.char_code;
          in_ch.first_char <= nxt.first_char;
          in_ch.str_pos    <= nxt.str_pos;
          in_ch.valid      <= 1'b1;
          in_gap = pause_len();   // idle before the following command
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      // result side stalls for the count drawn after its last transfer
      if (out_hold > 0) begin
        out_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: rising-edge sampling of both channels. Results are checked before
  // the command of the same edge is predicted, so queue order holds.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    scan_result_t want;
    text_cmd_t    took;
    if (rst_n) begin
      cycles++;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        out_hold = pause_len();
        if (owed_results.size() == 0) begin
          $error("result transfer with nothing owed: kind %0d reg %0h data %0h",
                 out_ch.kind, out_ch.reg_addr, out_ch.data_byte);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (out_ch.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
            mismatches++;
          end
          if (out_ch.reg_addr !== want.reg_addr) begin
            $error("reg_addr: expected %0h, got %0h", want.reg_addr, out_ch.reg_addr);
            mismatches++;
          end
          if (out_ch.data_byte !== want.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want.data_byte, out_ch.data_byte);
            mismatches++;
          end
          if (out_ch.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_ch.frame_end);
            mismatches++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            mismatches++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_ch.count);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        took.cmd        = in_ch.cmd;
        took.char_code  = in_ch.char_code;
        took.first_char = in_ch.first_char;
        took.str_pos    = in_ch.str_pos;
        predict_display(took);
        in_xfer = 1'b1;
        cmds_taken++;
        if (took.cmd == ssd_pkg::CMD_CHAR) chars_taken++;
        if (took.cmd == ssd_pkg::CMD_REFRESH) scans_taken++;
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results still owed", cycles,
                 owed_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_cmd(input logic [1:0] cmd, input logic [7:0] code,
                           input logic first, input logic [4:0] pos);
    text_cmd_t c;
    c.cmd        = cmd;
    c.char_code  = code;
    c.first_char = first;
    c.str_pos    = pos;
    cmd_queue.push_back(c);
  endtask

  // Block until every command has moved and every owed result came back,
  // then give the block time to finish commands that produce nothing.
  task automatic settle();
    while (cmd_queue.size() != 0 || in_ch.valid || owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, one cycle of cfg_we; the predictor copy follows at once.
  task automatic set_register(input logic [ssd_pkg::CFG_IDX_W-1:0] idx,
                              input logic [ssd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ssd_pkg::CFG_NUM_CHIPS: cfg_chips = val[2:0];
      ssd_pkg::CFG_REVERSE:   cfg_rev = val[0];
      ssd_pkg::CFG_INTENSITY: begin
        // only a changed level owes an intensity frame
        if (val != cfg_int) begin
          cfg_int  = val;
          int_owed = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // One random phase under a fresh register setting. Mostly strings that
  // start with first_char and run from short to past the end of the chain,
  // with points and a few unprintable codes; the rest is refreshes and noise.
  task automatic run_phase(input logic [2:0] chips, input logic rev,
                           input logic [3:0] level);
    int         lim;
    int         len;
    int         sent;
    int         pick;
    logic [7:0] code;
    logic [4:0] pos;
    settle();
    set_register(ssd_pkg::CFG_NUM_CHIPS, {1'b0, chips});
    set_register(ssd_pkg::CFG_REVERSE, {3'd0, rev});
    set_register(ssd_pkg::CFG_INTENSITY, level);
    settings_used++;
    lim  = chips_in_use() * ssd_pkg::DIGITS_PER_CHIP;
    sent = 0;
    while (sent < 12) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_cmd(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 5'($urandom));
        sent++;
      end else if (pick == 1) begin
        queue_cmd(ssd_pkg::CMD_REFRESH, 8'($urandom), 1'($urandom), 5'($urandom));
        sent++;
      end else begin
        len = $urandom_range(1, lim + 3);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 9);
          if (pick < 2) code = ssd_pkg::CHAR_POINT;
          else if (pick == 9) code = 8'($urandom_range(0, 255));
          else code = 8'($urandom_range(ssd_pkg::CHAR_SPACE, ssd_pkg::CHAR_TILDE));
          if (i == 0 && $urandom_range(0, 7) != 0) pos = 5'($urandom_range(0, lim - 1));
          else pos = 5'($urandom);
          // now and then a string continues the previous one
          queue_cmd(ssd_pkg::CMD_CHAR, code, i == 0 && $urandom_range(0, 5) != 0, pos);
          sent++;
        end
        if ($urandom_range(0, 1) == 1) begin
          queue_cmd(ssd_pkg::CMD_REFRESH, 8'($urandom), 1'($urandom), 5'($urandom));
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = ssd_pkg::CMD_CLEAR;
    in_ch.char_code  = 8'h00;
    in_ch.first_char = 1'b0;
    in_ch.str_pos    = 5'd0;
    out_ch.ready     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at reset settings: one chip, normal order, intensity 0.
    queue_cmd(ssd_pkg::CMD_REFRESH, 8'hA5, 1'b1, 5'h15);   // first refresh owes intensity
    queue_cmd(ssd_pkg::CMD_CHAR, 8'h30, 1'b1, 5'd0);
    queue_cmd(ssd_pkg::CMD_CHAR, ssd_pkg::CHAR_POINT, 1'b0, 5'h1F); // point on previous digit
    queue_cmd(ssd_pkg::CMD_CHAR, ssd_pkg::CHAR_POINT, 1'b0, 5'd0);  // second point, same digit
    queue_cmd(ssd_pkg::CMD_CHAR, 8'h00, 1'b0, 5'd0);       // below printable range
    queue_cmd(ssd_pkg::CMD_CHAR, 8'hFF, 1'b0, 5'd0);       // top code
    queue_cmd(ssd_pkg::CMD_CHAR, 8'h7F, 1'b0, 5'd0);       // just past tilde
    queue_cmd(ssd_pkg::CMD_CHAR, ssd_pkg::CHAR_SPACE, 1'b0, 5'd0);
    queue_cmd(ssd_pkg::CMD_CHAR, ssd_pkg::CHAR_TILDE, 1'b0, 5'd0);
    queue_cmd(ssd_pkg::CMD_CHAR, 8'h23, 1'b0, 5'd0);       // hole in the font
    queue_cmd(ssd_pkg::CMD_CHAR, 8'h41, 1'b0, 5'd0);       // fills the last digit
    queue_cmd(ssd_pkg::CMD_CHAR, 8'h7A, 1'b0, 5'd0);       // overflow, string stops
    queue_cmd(ssd_pkg::CMD_CHAR, ssd_pkg::CHAR_POINT, 1'b0, 5'd0);  // dropped while stopped
    queue_cmd(ssd_pkg::CMD_CHAR, ssd_pkg::CHAR_POINT, 1'b1, 5'd3);  // point at string start
    queue_cmd(ssd_pkg::CMD_CHAR, 8'h48, 1'b1, 5'd31);      // start beyond the chain
    queue_cmd(ssd_pkg::CMD_CHAR, ssd_pkg::CHAR_POINT, 1'b1, 5'd31); // point past chips: no OR
    queue_cmd(ssd_pkg::CMD_CHAR, ssd_pkg::CHAR_POINT, 1'b0, 5'd0);
    queue_cmd(ssd_pkg::CMD_REFRESH, 8'h00, 1'b0, 5'd0);
    queue_cmd(CMD_UNUSED, 8'h5A, 1'b1, 5'h0A);
    queue_cmd(ssd_pkg::CMD_CLEAR, 8'hFF, 1'b1, 5'h1F);
    queue_cmd(ssd_pkg::CMD_REFRESH, 8'h5A, 1'b0, 5'd0);    // blank buffer, no intensity
    queue_cmd(ssd_pkg::CMD_CHAR, 8'h37, 1'b1, 5'd0);
    queue_cmd(ssd_pkg::CMD_REFRESH, 8'h00, 1'b1, 5'd0);

    // Random phases: full chain reversed, chip count 0, above the maximum,
    // unchanged intensity, and finally a random setting.
    run_phase(3'd4, 1'b1, 4'd15);
    run_phase(3'd0, 1'b0, 4'd15);
    run_phase(3'd7, 1'b1, 4'd5);
    run_phase(3'd2, 1'b0, 4'd0);
    run_phase(3'd3, 1'b1, 4'd9);
    run_phase(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
              4'($urandom_range(0, 15)));
    settle();

    $display("Ran %0d commands (%0d characters, %0d refreshes) under %0d register settings,",
             cmds_taken, chars_taken, scans_taken, settings_used);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> seven_segment_text_scan_driver.f
+incdir+hdl
hdl/ssd_pkg.sv
hdl/ssd_ifs.sv
hdl/ssd_ram.sv
hdl/ssd_cfg.sv
hdl/ssd_seq.sv
hdl/seven_segment_text_scan_driver.sv
tb/seven_segment_text_scan_driver_tb.sv
